// ===== design/ggvc_pkg.sv =====
// shared constants and tables of the go-to-goal velocity controller
package ggvc_pkg;

    localparam int ANGLE_BITS   = 16;
    localparam int CORDIC_STEPS = 16;
    localparam int TAB_LEN      = 24;

    localparam int DW  = 45;   // working data width
    localparam int CW  = 37;   // cordic x/y width
    localparam int MW  = 77;   // multiplier accumulator width
    localparam int DVW = 32;   // divider steps
    localparam int CNT_W = $clog2(((CORDIC_STEPS > DVW) ? CORDIC_STEPS : DVW) + 1);

    localparam logic [31:0] INVK_Q24   = 32'd10188014;
    localparam logic [31:0] TWO_PI_Q29 = 32'd3373259426;

    localparam logic [1:0] ACT_START = 2'd0;
    localparam logic [1:0] ACT_STEP  = 2'd1;
    localparam logic [1:0] ACT_STOP  = 2'd2;
    localparam logic [1:0] ACT_SPARE = 2'd3;

    localparam logic [1:0] ST_INIT = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;
    localparam logic [1:0] ST_TERM = 2'd3;

    localparam logic [2:0] REG_GOAL_X = 3'd0;
    localparam logic [2:0] REG_GOAL_Y = 3'd1;
    localparam logic [2:0] REG_MODE   = 3'd2;
    localparam logic [2:0] REG_ARRIVE = 3'd3;
    localparam logic [2:0] REG_SGAIN  = 3'd4;
    localparam logic [2:0] REG_TGAIN  = 3'd5;
    localparam logic [2:0] REG_SLIM   = 3'd6;
    localparam logic [2:0] REG_TLIM   = 3'd7;

    function automatic logic [31:0] atan_turn(input logic [CNT_W-1:0] idx);
        logic [31:0] res;
        case (idx)
            0: res = 32'd536870912;
            1: res = 32'd316933406;
            2: res = 32'd167458907;
            3: res = 32'd85004756;
            4: res = 32'd42667331;
            5: res = 32'd21354465;
            6: res = 32'd10679838;
            7: res = 32'd5340245;
            8: res = 32'd2670163;
            9: res = 32'd1335087;
            10: res = 32'd667544;
            11: res = 32'd333772;
            12: res = 32'd166886;
            13: res = 32'd83443;
            14: res = 32'd41722;
            15: res = 32'd20861;
            16: res = 32'd10430;
            17: res = 32'd5215;
            18: res = 32'd2608;
            19: res = 32'd1304;
            20: res = 32'd652;
            21: res = 32'd326;
            22: res = 32'd163;
            23: res = 32'd81;
            default: res = 32'd0;
        endcase
        return res;
    endfunction

endpackage

// ===== design/go_to_goal_velocity_controller_unit.sv =====
// go-to-goal velocity controller: top level with sequencer, cordic, multiplier and divider
// A start or stop word goes straight to the output state and is answered once the output
// register takes it. A control step runs one shared shift-add CORDIC stage for 16 iterations,
// then a bit-serial multiplier (one multiplier bit a cycle) for the gain and scale products.
// Holonomic mode adds a second CORDIC pass, four more products and, per clipped component,
// a normalizing shift and a restoring divider. The input is stalled while a word is in work;
// a finished result waits in the output register.
module go_to_goal_velocity_controller_unit
    import ggvc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_action,
    input  logic signed [31:0] i_pose_x,
    input  logic signed [31:0] i_pose_y,
    input  logic [15:0]        i_heading,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [1:0]         o_status,
    output logic               o_command_valid,
    output logic signed [31:0] o_vel_forward,
    output logic signed [31:0] o_vel_lateral,
    output logic signed [31:0] o_turn_rate,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data
);

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_VEC  = 5'd1;
    localparam logic [4:0] S_MUL  = 5'd2;
    localparam logic [4:0] S_RCMP = 5'd3;
    localparam logic [4:0] S_V    = 5'd4;
    localparam logic [4:0] S_RAD  = 5'd5;
    localparam logic [4:0] S_WR   = 5'd6;
    localparam logic [4:0] S_ROT  = 5'd7;
    localparam logic [4:0] S_BX   = 5'd8;
    localparam logic [4:0] S_BY   = 5'd9;
    localparam logic [4:0] S_CX   = 5'd10;
    localparam logic [4:0] S_CY   = 5'd11;
    localparam logic [4:0] S_LIM  = 5'd12;
    localparam logic [4:0] S_NORM = 5'd13;
    localparam logic [4:0] S_DIVI = 5'd14;
    localparam logic [4:0] S_DIV  = 5'd15;
    localparam logic [4:0] S_OUT  = 5'd16;

    localparam int AL_W = ANGLE_BITS + 1;

    // configuration
    logic signed [31:0] r_goal_x, r_goal_y;
    logic [1:0]         r_mode;
    logic [30:0]        r_arrive, r_speed_limit, r_turn_limit;
    logic [15:0]        r_speed_gain, r_turn_gain;
    logic signed [31:0] r_origin_x, r_origin_y;

    // sequencer and datapath
    logic [4:0]             r_state, r_ret;
    logic [CNT_W-1:0]       r_cnt;
    logic signed [CW-1:0]   r_x, r_y;
    logic [31:0]            r_z;
    logic signed [33:0]     r_dx, r_dy;
    logic [15:0]            r_th;
    logic signed [MW-1:0]   r_ma, r_acc;
    logic [31:0]            r_mb;
    logic signed [DW-1:0]   r_v, r_cx, r_cy;
    logic [43:0]            r_a, r_m;
    logic [31:0]            r_rem, r_dq;
    logic                   r_ci;

    // result being built and output register
    logic [1:0]         r_w_status;
    logic               r_w_cv;
    logic signed [31:0] r_w_vf, r_w_vl, r_w_wr;
    logic               r_out_valid;
    logic [1:0]         r_o_status;
    logic               r_o_cv;
    logic signed [31:0] r_o_vf, r_o_vl, r_o_wr;

    // combinational helpers
    logic signed [33:0]   dx_in, dy_in;
    logic signed [CW-1:0] xs, ys;
    logic [31:0]          atan_v;
    logic                 cw_dir;
    logic signed [MW-1:0] t24, t_rad;
    logic signed [DW-1:0] rnd24, sh8, rad_v, cur_c, lim_s, tlim_s, neg_c;
    logic [31:0]          e_ang, rot_z;
    logic signed [32:0]   e33;
    logic signed [AL_W-1:0] al;
    logic [AL_W-1:0]      aa;
    logic [AL_W+4:0]      aa18;
    logic [43:0]          abs_c;
    logic [32:0]          div_t;
    logic                 div_ge;
    logic signed [31:0]   rot_zs;
    logic                 accept, out_load;

    assign accept   = i_valid && (r_state == S_IDLE);
    assign out_load = (r_state == S_OUT) && (!r_out_valid || !i_stall);

    assign dx_in = 34'(r_origin_x) + 34'(r_goal_x) - 34'(i_pose_x);
    assign dy_in = 34'(r_origin_y) + 34'(r_goal_y) - 34'(i_pose_y);

    assign xs     = r_x >>> r_cnt;
    assign ys     = r_y >>> r_cnt;
    assign atan_v = atan_turn(r_cnt);
    assign cw_dir = (r_state == S_VEC) ? r_y[CW-1] : !r_z[31];

    assign t24   = r_acc + MW'(1 << 23);
    assign rnd24 = DW'(t24 >>> 24);
    assign sh8   = DW'(r_acc >>> 8);
    assign t_rad = r_acc + MW'(64'sd1 << (ANGLE_BITS + 12));
    assign rad_v = DW'(t_rad >>> (ANGLE_BITS + 13));

    assign e_ang = r_z - {r_th, 16'd0};
    assign e33   = $signed({e_ang[31], e_ang}) + (33'sd1 <<< (31 - ANGLE_BITS));
    assign al    = AL_W'(e33 >>> (32 - ANGLE_BITS));
    assign aa    = al[AL_W-1] ? AL_W'(-al) : AL_W'(al);
    assign aa18  = (AL_W+5)'(aa) * (AL_W+5)'(18);

    assign rot_z  = 32'd0 - {r_th, 16'd0};
    assign rot_zs = $signed(rot_z);

    assign lim_s  = $signed(DW'(r_speed_limit));
    assign tlim_s = $signed(DW'(r_turn_limit));
    assign cur_c  = r_ci ? r_cy : r_cx;
    assign neg_c  = -cur_c;
    assign abs_c  = cur_c[DW-1] ? neg_c[43:0] : cur_c[43:0];

    assign div_t  = {r_rem, r_dq[31]};
    assign div_ge = div_t >= {1'b0, r_m[31:0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_goal_x      <= '0;
            r_goal_y      <= '0;
            r_mode        <= '0;
            r_arrive      <= 31'd6554;
            r_speed_gain  <= 16'd256;
            r_turn_gain   <= 16'd256;
            r_speed_limit <= 31'd65536;
            r_turn_limit  <= 31'd65536;
            r_origin_x    <= '0;
            r_origin_y    <= '0;
            r_state       <= S_IDLE;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_GOAL_X: r_goal_x      <= $signed(i_cfg_data);
                    REG_GOAL_Y: r_goal_y      <= $signed(i_cfg_data);
                    REG_MODE:   r_mode        <= i_cfg_data[1:0];
                    REG_ARRIVE: r_arrive      <= i_cfg_data[30:0];
                    REG_SGAIN:  r_speed_gain  <= i_cfg_data[15:0];
                    REG_TGAIN:  r_turn_gain   <= i_cfg_data[15:0];
                    REG_SLIM:   r_speed_limit <= i_cfg_data[30:0];
                    REG_TLIM:   r_turn_limit  <= i_cfg_data[30:0];
                    default: ;
                endcase
            end

            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state) inside
                S_IDLE: begin
                    if (accept) begin
                        r_dx     <= dx_in;
                        r_dy     <= dy_in;
                        r_th     <= i_heading;
                        r_w_vf   <= '0;
                        r_w_vl   <= '0;
                        r_w_wr   <= '0;
                        r_w_cv   <= 1'b0;
                        if (i_action == ACT_START) begin
                            r_origin_x <= r_mode[0] ? i_pose_x : 32'sd0;
                            r_origin_y <= r_mode[0] ? i_pose_y : 32'sd0;
                            r_w_status <= ST_INIT;
                            r_state    <= S_OUT;
                        end else if (i_action == ACT_STEP) begin
                            if (dx_in == 34'sd0 && dy_in == 34'sd0) begin
                                r_x   <= '0;
                                r_y   <= '0;
                                r_z   <= '0;
                                r_cnt <= CNT_W'(CORDIC_STEPS);
                            end else if (dx_in[33]) begin
                                r_x   <= -CW'(dx_in);
                                r_y   <= -CW'(dy_in);
                                r_z   <= 32'h8000_0000;
                                r_cnt <= '0;
                            end else begin
                                r_x   <= CW'(dx_in);
                                r_y   <= CW'(dy_in);
                                r_z   <= '0;
                                r_cnt <= '0;
                            end
                            r_state <= S_VEC;
                        end else begin
                            r_w_status <= ST_TERM;
                            r_w_cv     <= 1'b1;
                            r_state    <= S_OUT;
                        end
                    end
                end
                S_VEC, S_ROT: begin
                    if (r_cnt == CNT_W'(CORDIC_STEPS)) begin
                        r_ma    <= MW'(r_x);
                        r_mb    <= INVK_Q24;
                        r_acc   <= '0;
                        r_ret   <= (r_state == S_VEC) ? S_RCMP : S_BX;
                        r_state <= S_MUL;
                    end else begin
                        if (cw_dir) begin
                            r_x <= r_x - ys;
                            r_y <= r_y + xs;
                            r_z <= r_z - atan_v;
                        end else begin
                            r_x <= r_x + ys;
                            r_y <= r_y - xs;
                            r_z <= r_z + atan_v;
                        end
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_MUL: begin
                    if (r_mb == 32'd0) begin
                        r_state <= r_ret;
                    end else begin
                        if (r_mb[0]) begin
                            r_acc <= r_acc + r_ma;
                        end
                        r_ma <= r_ma <<< 1;
                        r_mb <= r_mb >> 1;
                    end
                end
                S_RCMP: begin
                    if (rnd24 < $signed(DW'(r_arrive))) begin
                        r_w_status <= ST_DONE;
                        r_state    <= S_OUT;
                    end else begin
                        r_w_status <= ST_RUN;
                        r_w_cv     <= 1'b1;
                        r_ma       <= MW'(rnd24);
                        r_mb       <= 32'(r_speed_gain);
                        r_acc      <= '0;
                        r_ret      <= S_V;
                        r_state    <= S_MUL;
                    end
                end
                S_V: begin
                    r_v <= sh8;
                    if (r_mode[1]) begin
                        if (rot_zs > 32'sh4000_0000 || rot_zs < -32'sh4000_0000) begin
                            r_x <= -CW'(r_dx);
                            r_y <= -CW'(r_dy);
                            r_z <= rot_z ^ 32'h8000_0000;
                        end else begin
                            r_x <= CW'(r_dx);
                            r_y <= CW'(r_dy);
                            r_z <= rot_z;
                        end
                        r_cnt   <= '0;
                        r_state <= S_ROT;
                    end else if (aa18 > (AL_W+5)'(1 << ANGLE_BITS)) begin
                        r_w_wr  <= (al > 0) ? 32'(tlim_s) : 32'(-tlim_s);
                        r_state <= S_OUT;
                    end else begin
                        r_ma    <= MW'(al);
                        r_mb    <= TWO_PI_Q29;
                        r_acc   <= '0;
                        r_ret   <= S_RAD;
                        r_state <= S_MUL;
                    end
                end
                S_RAD: begin
                    r_ma    <= MW'(rad_v);
                    r_mb    <= 32'(r_turn_gain);
                    r_acc   <= '0;
                    r_ret   <= S_WR;
                    r_state <= S_MUL;
                end
                S_WR: begin
                    if (sh8 > tlim_s) begin
                        r_w_wr <= 32'(tlim_s);
                    end else if (sh8 < -tlim_s) begin
                        r_w_wr <= 32'(-tlim_s);
                    end else begin
                        r_w_wr <= 32'(sh8);
                    end
                    r_w_vf  <= (r_v > lim_s) ? 32'(lim_s) : 32'(r_v);
                    r_state <= S_OUT;
                end
                S_BX: begin
                    r_cx    <= rnd24;
                    r_ma    <= MW'(r_y);
                    r_mb    <= INVK_Q24;
                    r_acc   <= '0;
                    r_ret   <= S_BY;
                    r_state <= S_MUL;
                end
                S_BY: begin
                    r_cy    <= rnd24;
                    r_ma    <= MW'(r_cx);
                    r_mb    <= 32'(r_speed_gain);
                    r_acc   <= '0;
                    r_ret   <= S_CX;
                    r_state <= S_MUL;
                end
                S_CX: begin
                    r_cx    <= sh8;
                    r_ma    <= MW'(r_cy);
                    r_mb    <= 32'(r_speed_gain);
                    r_acc   <= '0;
                    r_ret   <= S_CY;
                    r_state <= S_MUL;
                end
                S_CY: begin
                    r_cy    <= sh8;
                    r_ci    <= 1'b0;
                    r_state <= S_LIM;
                end
                S_LIM: begin
                    if (cur_c <= lim_s && cur_c >= -lim_s) begin
                        if (r_ci) begin
                            r_w_vl  <= 32'(cur_c);
                            r_state <= S_OUT;
                        end else begin
                            r_w_vf <= 32'(cur_c);
                            r_ci   <= 1'b1;
                        end
                    end else begin
                        r_a     <= abs_c;
                        r_m     <= (r_v[43:0] > abs_c) ? r_v[43:0] : abs_c;
                        r_state <= S_NORM;
                    end
                end
                S_NORM: begin
                    if (r_m[43:32] != 12'd0) begin
                        r_m <= r_m >> 1;
                        r_a <= r_a >> 1;
                    end else begin
                        r_ma    <= MW'(r_a);
                        r_mb    <= 32'(r_speed_limit);
                        r_acc   <= '0;
                        r_ret   <= S_DIVI;
                        r_state <= S_MUL;
                    end
                end
                S_DIVI: begin
                    r_rem   <= 32'(r_acc[62:32]);
                    r_dq    <= r_acc[31:0];
                    r_cnt   <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (r_cnt == CNT_W'(DVW)) begin
                        if (r_ci) begin
                            r_w_vl  <= cur_c[DW-1] ? -$signed(r_dq) : $signed(r_dq);
                            r_state <= S_OUT;
                        end else begin
                            r_w_vf  <= cur_c[DW-1] ? -$signed(r_dq) : $signed(r_dq);
                            r_ci    <= 1'b1;
                            r_state <= S_LIM;
                        end
                    end else begin
                        r_rem <= div_ge ? 32'(div_t - {1'b0, r_m[31:0]}) : div_t[31:0];
                        r_dq  <= {r_dq[30:0], div_ge};
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_OUT: begin
                    if (out_load) begin
                        r_o_status <= r_w_status;
                        r_o_cv     <= r_w_cv;
                        r_o_vf     <= r_w_vf;
                        r_o_vl     <= r_w_vl;
                        r_o_wr     <= r_w_wr;
                        r_state    <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_stall         = (r_state != S_IDLE);
    assign o_valid         = r_out_valid;
    assign o_status        = r_o_status;
    assign o_command_valid = r_o_cv;
    assign o_vel_forward   = r_o_vf;
    assign o_vel_lateral   = r_o_vl;
    assign o_turn_rate     = r_o_wr;

    a_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DIV |-> r_cnt <= CNT_W'(DVW))
        else $error("divider ran past its last step");

    a_mul_ret: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_MUL |-> r_ret != S_MUL && r_ret != S_IDLE)
        else $error("multiplier has no return state");

    a_done_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_DONE |->
            !o_command_valid && o_vel_forward == 0 && o_vel_lateral == 0 && o_turn_rate == 0)
        else $error("completed word carries a command");

    a_term_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_TERM || o_status == ST_RUN) |-> o_command_valid)
        else $error("running or stop word without command");

endmodule

// ===== tb/tb_go_to_goal_velocity_controller_unit.sv =====
// testbench of the go-to-goal velocity controller: predicted words checked against the block
`timescale 1ns / 100ps

module tb_go_to_goal_velocity_controller_unit;
    import ggvc_pkg::*;

    typedef struct {
        logic [1:0]  status;
        logic        cmd;
        logic [31:0] vf;
        logic [31:0] vl;
        logic [31:0] wr;
    } vel_word_t;

    class vel_scoreboard;
        longint goal_x, goal_y, org_x, org_y;
        int unsigned mode, arrive, sgain, tgain, slim, tlim;
        vel_word_t pending[$];
        int errors;
        int shown;

        function void clear_regs();
            goal_x = 0; goal_y = 0; mode = 0; arrive = 6554;
            sgain = 256; tgain = 256; slim = 65536; tlim = 65536;
            org_x = 0; org_y = 0; errors = 0; shown = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [31:0] d);
            case (idx)
                REG_GOAL_X: goal_x = longint'($signed(d));
                REG_GOAL_Y: goal_y = longint'($signed(d));
                REG_MODE:   mode = d[1:0];
                REG_ARRIVE: arrive = d[30:0];
                REG_SGAIN:  sgain = d[15:0];
                REG_TGAIN:  tgain = d[15:0];
                REG_SLIM:   slim = d[30:0];
                default:    tlim = d[30:0];
            endcase
        endfunction

        function longint round_shift(longint v, int s);
            return (v + (longint'(1) << (s - 1))) >>> s;
        endfunction

        function longint clip_part(longint c, longint v, longint lim);
            longint unsigned a, m;
            longint q;
            if (c <= lim && c >= -lim) return c;
            a = c < 0 ? -c : c;
            m = v > a ? v : a;
            while (m > 64'hFFFF_FFFF) begin
                m = m >> 1;
                a = a >> 1;
            end
            q = (lim * a) / m;
            return c < 0 ? -q : q;
        endfunction

        function void note_pose(logic [1:0] act, logic [31:0] px32, logic [31:0] py32,
                                logic [15:0] hd);
            vel_word_t w;
            longint px, py, dx, dy, x, y, xs, ys, r, v, bx, by, e, al, aa, rad, wr;
            logic [31:0] z, th, t;
            longint zs;
            px = longint'($signed(px32));
            py = longint'($signed(py32));
            th = {hd, 16'h0};
            w.status = ST_TERM; w.cmd = 1; w.vf = 0; w.vl = 0; w.wr = 0;
            if (act == ACT_START) begin
                org_x = mode[0] ? px : 0;
                org_y = mode[0] ? py : 0;
                w.status = ST_INIT; w.cmd = 0;
            end else if (act == ACT_STEP) begin
                dx = org_x + goal_x - px;
                dy = org_y + goal_y - py;
                x = dx; y = dy; z = 0;
                if (dx == 0 && dy == 0) begin
                    r = 0;
                end else begin
                    if (dx < 0) begin
                        x = -dx; y = -dy; z = 32'h8000_0000;
                    end
                    for (int i = 0; i < CORDIC_STEPS; i++) begin
                        xs = x >>> i; ys = y >>> i;
                        if (y < 0) begin
                            x -= ys; y += xs; z -= atan_tab(i);
                        end else begin
                            x += ys; y -= xs; z += atan_tab(i);
                        end
                    end
                    r = round_shift(x * 10188014, 24);
                end
                if (r < arrive) begin
                    w.status = ST_DONE; w.cmd = 0;
                end else begin
                    v = (longint'(sgain) * r) >>> 8;
                    w.status = ST_RUN;
                    if (mode[1]) begin
                        t = 32'd0 - th;
                        zs = longint'($signed(t));
                        x = dx; y = dy;
                        if (zs > 64'sh4000_0000 || zs < -64'sh4000_0000) begin
                            x = -x; y = -y;
                            zs = zs > 0 ? zs - 64'sh8000_0000 : zs + 64'sh8000_0000;
                        end
                        for (int i = 0; i < CORDIC_STEPS; i++) begin
                            xs = x >>> i; ys = y >>> i;
                            if (zs >= 0) begin
                                x -= ys; y += xs; zs -= atan_tab(i);
                            end else begin
                                x += ys; y -= xs; zs += atan_tab(i);
                            end
                        end
                        bx = (longint'(sgain) * round_shift(x * 10188014, 24)) >>> 8;
                        by = (longint'(sgain) * round_shift(y * 10188014, 24)) >>> 8;
                        w.vf = clip_part(bx, v, slim);
                        w.vl = clip_part(by, v, slim);
                    end else begin
                        t = z - th;
                        e = longint'($signed(t));
                        al = (e + (longint'(1) << (31 - ANGLE_BITS))) >>> (32 - ANGLE_BITS);
                        aa = al < 0 ? -al : al;
                        if (aa * 18 > (longint'(1) << ANGLE_BITS)) begin
                            wr = al > 0 ? tlim : -longint'(tlim);
                        end else begin
                            rad = round_shift(al * 64'sd3373259426, ANGLE_BITS + 13);
                            wr = (longint'(tgain) * rad) >>> 8;
                            if (wr > longint'(tlim)) wr = tlim;
                            if (wr < -longint'(tlim)) wr = -longint'(tlim);
                            w.vf = v > slim ? slim : v;
                        end
                        w.wr = wr;
                    end
                end
            end
            pending.push_back(w);
        endfunction

        function longint atan_tab(int i);
            return longint'(atan_turn(i));
        endfunction

        function void check_word(vel_word_t got);
            vel_word_t exp_w;
            if (pending.size() == 0) begin
                errors++;
                if (shown < 10) begin
                    shown++;
                    $display("unexpected output word status %0d", got.status);
                end
                return;
            end
            exp_w = pending.pop_front();
            if (got.status !== exp_w.status || got.cmd !== exp_w.cmd || got.vf !== exp_w.vf ||
                got.vl !== exp_w.vl || got.wr !== exp_w.wr) begin
                errors++;
                if (shown < 10) begin
                    shown++;
                    $display("mismatch exp %0d %0d %h %h %h got %0d %0d %h %h %h",
                             exp_w.status, exp_w.cmd, exp_w.vf, exp_w.vl, exp_w.wr,
                             got.status, got.cmd, got.vf, got.vl, got.wr);
                end
            end
        endfunction
    endclass

    logic i_clk = 0, i_rst_n = 0, i_valid = 0, i_stall = 1, i_cfg_we = 0;
    logic [1:0] i_action = 0;
    logic signed [31:0] i_pose_x = 0, i_pose_y = 0;
    logic [15:0] i_heading = 0;
    logic [2:0] i_cfg_index = 0;
    logic [31:0] i_cfg_data = 0;
    logic o_stall, o_valid, o_command_valid;
    logic [1:0] o_status;
    logic signed [31:0] o_vel_forward, o_vel_lateral, o_turn_rate;
    vel_scoreboard board;
    longint cycles = 0;

    go_to_goal_velocity_controller_unit dut (.*);

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        vel_word_t got;
        cycles <= cycles + 1;
        if (cycles > 3000000) begin
            $display("tb_go_to_goal_velocity_controller_unit NOT OK");
            $finish;
        end
        if (i_rst_n && o_valid && !i_stall) begin
            got.status = o_status; got.cmd = o_command_valid; got.vf = o_vel_forward;
            got.vl = o_vel_lateral; got.wr = o_turn_rate;
            board.check_word(got);
        end
    end

    // receiver stalls drawn per word
    initial begin
        int n;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
            if (n > 0) begin
                i_stall <= 1;
                repeat (n) @(negedge i_clk);
            end
            i_stall <= 0;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    task automatic write_cfg(logic [2:0] idx, logic [31:0] d);
        @(negedge i_clk);
        i_cfg_we <= 1; i_cfg_index <= idx; i_cfg_data <= d;
        board.write_reg(idx, d);
        @(negedge i_clk);
        i_cfg_we <= 0;
    endtask

    task automatic wait_drained();
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
    endtask

    task automatic send_pose(logic [1:0] act, logic [31:0] px, logic [31:0] py,
                             logic [15:0] hd, bit no_gap);
        int g;
        g = no_gap ? 0 : $urandom_range(0, 10);
        @(negedge i_clk);
        if (g > 0) begin
            i_valid <= 0;
            repeat (g) @(negedge i_clk);
        end
        i_valid <= 1; i_action <= act; i_pose_x <= px; i_pose_y <= py; i_heading <= hd;
        do @(posedge i_clk); while (o_stall);
        board.note_pose(act, px, py, hd);
    endtask

    function automatic logic [31:0] rand_pos();
        case ($urandom_range(0, 4))
            0: return $urandom;
            1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return $signed($urandom_range(0, 20 * 65536)) - 10 * 65536;
        endcase
    endfunction

    task automatic random_phase(int count);
        logic [1:0] a;
        for (int k = 0; k < count; k++) begin
            case ($urandom_range(0, 9))
                0: a = ACT_START;
                1: a = ($urandom_range(0, 3) == 0) ? ACT_SPARE : ACT_STOP;
                default: a = ACT_STEP;
            endcase
            send_pose(a, rand_pos(), rand_pos(), $urandom, $urandom_range(0, 4) == 0);
            @(negedge i_clk);
            i_valid <= 0;
        end
    endtask

    task automatic random_cfg();
        write_cfg(REG_GOAL_X, rand_pos());
        write_cfg(REG_GOAL_Y, rand_pos());
        write_cfg(REG_MODE, $urandom_range(0, 3));
        write_cfg(REG_ARRIVE, $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 65536));
        write_cfg(REG_SGAIN, $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 1024));
        write_cfg(REG_TGAIN, $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 1024));
        write_cfg(REG_SLIM, $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 262144));
        write_cfg(REG_TLIM, $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 262144));
    endtask

    initial begin
        board = new();
        board.clear_regs();
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1;
        // directed words
        send_pose(ACT_STEP, 0, 0, 0, 0);
        send_pose(ACT_START, 32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF, 0);
        send_pose(ACT_STEP, 32'h0001_0000, 0, 16'h0000, 0);
        send_pose(ACT_STEP, 32'h0002_0000, 0, 16'h0000, 0);
        send_pose(ACT_STEP, 32'h0002_0000, 0, 16'h8000, 1);
        send_pose(ACT_STEP, 32'h8000_0000, 32'h8000_0000, 16'h1234, 0);
        send_pose(ACT_STEP, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'hFFFF, 0);
        send_pose(ACT_STOP, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'hFFFF, 0);
        send_pose(ACT_SPARE, 0, 0, 0, 0);
        @(negedge i_clk);
        i_valid <= 0;
        wait_drained();
        write_cfg(REG_MODE, 3);
        write_cfg(REG_GOAL_X, 32'h7FFF_FFFF);
        write_cfg(REG_GOAL_Y, 32'h8000_0000);
        write_cfg(REG_ARRIVE, 0);
        write_cfg(REG_SGAIN, 16'hFFFF);
        write_cfg(REG_TGAIN, 16'hFFFF);
        write_cfg(REG_SLIM, 32'h7FFF_FFFF);
        write_cfg(REG_TLIM, 0);
        send_pose(ACT_START, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0);
        send_pose(ACT_STEP, 32'h7FFF_FFFF, 32'h8000_0000, 16'h4000, 0);
        send_pose(ACT_STEP, 0, 0, 16'hC000, 0);
        @(negedge i_clk);
        i_valid <= 0;
        wait_drained();
        write_cfg(REG_SLIM, 0);
        send_pose(ACT_STEP, 0, 0, 16'h2000, 0);
        @(negedge i_clk);
        i_valid <= 0;
        wait_drained();
        for (int p = 0; p < 12; p++) begin
            random_cfg();
            random_phase(120);
            wait_drained();
        end
        if (board.errors == 0)
            $display("tb_go_to_goal_velocity_controller_unit OK");
        else
            $display("tb_go_to_goal_velocity_controller_unit NOT OK");
        $finish;
    end

endmodule
